FILE: hdl/urtb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urtb_pkg: shared types and codes for the serial port ring buffer pair
// Event kinds, result status codes, the sequencer state encoding and the
// command group that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package urtb_pkg;

    typedef enum logic [1:0] {
        KIND_LINE_RX  = 2'd0,
        KIND_TX_READY = 2'd1,
        KIND_HOST_RD  = 2'd2,
        KIND_HOST_WR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_RX_DROP  = 2'd1,
        STATUS_TX_RETRY = 2'd2,
        STATUS_TX_DROP  = 2'd3
    } status_t;

    // One-hot sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the accepted event
        logic execute;   // apply the event to the rings and load the result
    } dp_cmd_t;

endpackage

FILE: hdl/urtb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urtb_ctrl: event sequencer
// Accepts one event, lets the datapath apply it, then holds the result until
// the downstream side takes it.
// ----------------------------------------------------------------------------
module urtb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output urtb_pkg::dp_cmd_t cmd
);

    urtb_pkg::state_t state_reg;
    urtb_pkg::state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            urtb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = urtb_pkg::ST_EXEC;
                end
            end
            urtb_pkg::ST_EXEC: begin
                state_next = urtb_pkg::ST_RESP;
            end
            urtb_pkg::ST_RESP: begin
                if (m_ready) begin
                    state_next = urtb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = urtb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= urtb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready     = (state_reg == urtb_pkg::ST_IDLE);
    assign m_valid     = (state_reg == urtb_pkg::ST_RESP);
    assign cmd.capture = s_ready && s_valid;
    assign cmd.execute = (state_reg == urtb_pkg::ST_EXEC);

    // The state register always holds exactly one active bit.
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    // The input and result sides are never open in the same cycle.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a result is pending");

    // Every captured event is executed in the following cycle.
    a_capture_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> cmd.execute)
        else $error("captured event was not executed");

endmodule

FILE: hdl/urtb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urtb_datapath: ring memories, pointers and result registers
// Holds both rings and the transmit-request flag and produces the result
// of each event in the cycle after the execute command.
// ----------------------------------------------------------------------------
module urtb_datapath #(
    parameter int RING_DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  urtb_pkg::dp_cmd_t cmd,
    input  logic [1:0]        s_kind,
    input  logic [7:0]        s_in_byte,
    input  logic              s_may_block,
    output logic [7:0]        m_out_byte,
    output logic              m_out_valid,
    output logic [1:0]        m_status,
    output logic [5:0]        m_rx_count,
    output logic [5:0]        m_tx_free,
    output logic              m_tx_request
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0] MAX_FILL = CNT_W'(RING_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] ring_used(input logic [PTR_W-1:0] w,
                                                   input logic [PTR_W-1:0] r);
        logic [CNT_W-1:0] wx;
        logic [CNT_W-1:0] rx;
        wx = {1'b0, w};
        rx = {1'b0, r};
        if (w >= r) begin
            return wx - rx;
        end else begin
            return wx + DEPTH_C - rx;
        end
    endfunction

    // Ring memories; every slot is written before it is ever read.
    logic [7:0] rx_mem [RING_DEPTH];
    logic [7:0] tx_mem [RING_DEPTH];

    // Captured event.
    urtb_pkg::kind_t kind_reg;
    logic [7:0]      byte_reg;
    logic            block_reg;

    logic [PTR_W-1:0] rx_wr_ptr_reg, rx_wr_ptr_next;
    logic [PTR_W-1:0] rx_rd_ptr_reg, rx_rd_ptr_next;
    logic [PTR_W-1:0] tx_wr_ptr_reg, tx_wr_ptr_next;
    logic [PTR_W-1:0] tx_rd_ptr_reg, tx_rd_ptr_next;
    logic             tx_req_reg, tx_req_next;

    logic [7:0]             rx_q_reg;
    logic [7:0]             tx_q_reg;
    logic                   ov_reg, ov_next;
    urtb_pkg::status_t      status_reg, status_next;
    logic [CNT_W-1:0]       rx_cnt_reg;
    logic [CNT_W-1:0]       tx_free_reg;
    logic [CNT_W-1:0]       rx_used_now;
    logic [CNT_W-1:0]       tx_used_now;

    logic rx_full, rx_empty, tx_full, tx_empty;
    logic push_rx, pop_rx, push_tx, pop_tx;

    assign rx_used_now = ring_used(rx_wr_ptr_reg, rx_rd_ptr_reg);
    assign tx_used_now = ring_used(tx_wr_ptr_reg, tx_rd_ptr_reg);
    assign rx_full  = (rx_used_now == MAX_FILL);
    assign tx_full  = (tx_used_now == MAX_FILL);
    assign rx_empty = (rx_wr_ptr_reg == rx_rd_ptr_reg);
    assign tx_empty = (tx_wr_ptr_reg == tx_rd_ptr_reg);

    assign push_rx = cmd.execute && (kind_reg == urtb_pkg::KIND_LINE_RX)  && !rx_full;
    assign pop_tx  = cmd.execute && (kind_reg == urtb_pkg::KIND_TX_READY) && !tx_empty;
    assign pop_rx  = cmd.execute && (kind_reg == urtb_pkg::KIND_HOST_RD)  && !rx_empty;
    assign push_tx = cmd.execute && (kind_reg == urtb_pkg::KIND_HOST_WR)  && !tx_full;

    always_comb begin
        rx_wr_ptr_next = push_rx ? ptr_inc(rx_wr_ptr_reg) : rx_wr_ptr_reg;
        rx_rd_ptr_next = pop_rx  ? ptr_inc(rx_rd_ptr_reg) : rx_rd_ptr_reg;
        tx_wr_ptr_next = push_tx ? ptr_inc(tx_wr_ptr_reg) : tx_wr_ptr_reg;
        tx_rd_ptr_next = pop_tx  ? ptr_inc(tx_rd_ptr_reg) : tx_rd_ptr_reg;
        tx_req_next    = tx_req_reg;
        ov_next        = pop_rx || pop_tx;
        status_next    = urtb_pkg::STATUS_OK;
        if (cmd.execute) begin
            unique case (kind_reg)
                urtb_pkg::KIND_LINE_RX: begin
                    if (rx_full) begin
                        status_next = urtb_pkg::STATUS_RX_DROP;
                    end
                end
                urtb_pkg::KIND_TX_READY: begin
                    if (tx_empty) begin
                        tx_req_next = 1'b0;
                    end
                end
                urtb_pkg::KIND_HOST_RD: begin
                    status_next = urtb_pkg::STATUS_OK;
                end
                urtb_pkg::KIND_HOST_WR: begin
                    tx_req_next = 1'b1;
                    if (tx_full) begin
                        status_next = block_reg ? urtb_pkg::STATUS_TX_RETRY
                                                : urtb_pkg::STATUS_TX_DROP;
                    end
                end
                default: begin
                    status_next = urtb_pkg::STATUS_OK;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_wr_ptr_reg <= '0;
            rx_rd_ptr_reg <= '0;
            tx_wr_ptr_reg <= '0;
            tx_rd_ptr_reg <= '0;
            tx_req_reg    <= 1'b1;
        end else begin
            rx_wr_ptr_reg <= rx_wr_ptr_next;
            rx_rd_ptr_reg <= rx_rd_ptr_next;
            tx_wr_ptr_reg <= tx_wr_ptr_next;
            tx_rd_ptr_reg <= tx_rd_ptr_next;
            tx_req_reg    <= tx_req_next;
        end
    end

    // Event capture and result registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg  <= urtb_pkg::kind_t'(s_kind);
            byte_reg  <= s_in_byte;
            block_reg <= s_may_block;
        end
        if (cmd.execute) begin
            ov_reg      <= ov_next;
            status_reg  <= status_next;
            rx_cnt_reg  <= ring_used(rx_wr_ptr_next, rx_rd_ptr_next);
            tx_free_reg <= MAX_FILL - ring_used(tx_wr_ptr_next, tx_rd_ptr_next);
        end
    end

    // Ring memories: one write and one registered read each.
    always_ff @(posedge aclk) begin
        if (push_rx) begin
            rx_mem[rx_wr_ptr_reg] <= byte_reg;
        end
        if (pop_rx) begin
            rx_q_reg <= rx_mem[rx_rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (push_tx) begin
            tx_mem[tx_wr_ptr_reg] <= byte_reg;
        end
        if (pop_tx) begin
            tx_q_reg <= tx_mem[tx_rd_ptr_reg];
        end
    end

    always_comb begin
        m_out_byte = 8'd0;
        if (ov_reg) begin
            m_out_byte = (kind_reg == urtb_pkg::KIND_HOST_RD) ? rx_q_reg : tx_q_reg;
        end
    end

    assign m_out_valid  = ov_reg;
    assign m_status     = status_reg;
    assign m_rx_count   = 6'(rx_cnt_reg);
    assign m_tx_free    = 6'(tx_free_reg);
    assign m_tx_request = tx_req_reg;

    // A host write always leaves the transmit-request flag set.
    a_wr_sets_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.execute && kind_reg == urtb_pkg::KIND_HOST_WR) |=> tx_req_reg)
        else $error("host write did not set transmit request");

    // A full receive ring never advances its write pointer.
    a_rx_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.execute && kind_reg == urtb_pkg::KIND_LINE_RX && rx_full)
        |=> $stable(rx_wr_ptr_reg))
        else $error("receive ring overwritten while full");

    // Neither ring ever holds more than one slot short of its depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (rx_used_now <= MAX_FILL) && (tx_used_now <= MAX_FILL))
        else $error("ring fill level out of range");

endmodule

FILE: hdl/uart_rx_tx_ring_buffers.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers: receive and transmit ring buffers for a serial port
// A receive ring is filled from the line and drained by the host; a transmit
// ring is filled by the host and drained toward the line. Each ring keeps one
// slot empty, so it holds at most RING_DEPTH-1 bytes.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                      | Carries
//  ---------+--------------------------------------------+------------------------
//  event    | s_valid/s_ready, s_kind, s_in_byte,        | one ring event
//           | s_may_block                                |
//  result   | m_valid/m_ready, m_out_byte, m_out_valid,  | one result per event
//           | m_status, m_rx_count, m_tx_free,           |
//           | m_tx_request                               |
//
// Each event passes through three steps: acceptance in the idle state, an
// execute step in which the rings and pointers are updated and the popped
// byte is read from the ring memory into its output register, and a response
// step in which the result is offered until m_ready takes it.
// One event is in flight at a time; s_ready is low from acceptance until the
// result transfer completes, so a stalled m_ready holds off the input side.
// Reset (aresetn low, synchronous) empties both rings and sets the
// transmit-request flag; the ring memories themselves are not cleared, as no
// slot is read before it has been written.
//
module uart_rx_tx_ring_buffers #(
    parameter int RING_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Event channel.
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_kind,
    input  logic [7:0] s_in_byte,
    input  logic       s_may_block,
    // Result channel.
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_valid,
    output logic [1:0] m_status,
    output logic [5:0] m_rx_count,
    output logic [5:0] m_tx_free,
    output logic       m_tx_request
);

    // Commands from the sequencer to the datapath.
    urtb_pkg::dp_cmd_t cmd;

    // The sequencer owns both handshakes and steps each event through
    // capture, execute and response.
    urtb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // The datapath holds the rings, their pointers, the transmit-request
    // flag and the result registers, which stay stable while m_valid waits.
    urtb_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_kind       (s_kind),
        .s_in_byte    (s_in_byte),
        .s_may_block  (s_may_block),
        .m_out_byte   (m_out_byte),
        .m_out_valid  (m_out_valid),
        .m_status     (m_status),
        .m_rx_count   (m_rx_count),
        .m_tx_free    (m_tx_free),
        .m_tx_request (m_tx_request)
    );

endmodule
